// ===== hw/rtl/lcfd_pkg.sv =====
// lcfd_pkg: shared types, register codes and constants for the curb feature detector
// no dependencies; used by every other file of the block but lcfd_ram
`default_nettype none

package lcfd_pkg;

	// register file layout
	localparam int NUM_REGS = 6;
	localparam int PADDR_W  = 5;
	localparam logic [2:0] REG_HEIGHT_REGION   = 3'd0;
	localparam logic [2:0] REG_SLOPE_REGION    = 3'd1;
	localparam logic [2:0] REG_SLOPE_THRESHOLD = 3'd2;
	localparam logic [2:0] REG_HEIGHT_DIFF_MIN = 3'd3;
	localparam logic [2:0] REG_HEIGHT_DIFF_MAX = 3'd4;
	localparam logic [2:0] REG_MIN_SCAN_POINTS = 3'd5;

	// field widths fixed by the register map and result format
	localparam int REGION_W = 5;
	localparam int THR_W    = 17;
	localparam int HDIFF_W  = 17;
	localparam int SIZE_W   = 13;
	localparam int INDEX_W  = 12;
	// step counter covers the height window (2*31), the root digits (<=32) and cordic
	localparam int STEP_W   = 6;

	// cordic vectoring
	localparam int CORDIC_STEPS = 20;
	localparam int ACC_W        = 25;
	localparam int ANG_W        = 17;

	typedef struct packed {
		logic [REGION_W-1:0]     height_region;
		logic [REGION_W-1:0]     slope_region;
		logic signed [THR_W-1:0] slope_threshold;
		logic [HDIFF_W-1:0]      height_diff_min;
		logic [HDIFF_W-1:0]      height_diff_max;
		logic [SIZE_W-1:0]       min_scan_points;
	} cfg_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_HGT,
		RD_PA,
		RD_PB,
		RD_PC
	} rd_kind_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_WRITE,
		ST_HREAD,
		ST_HLAST,
		ST_HCHK,
		ST_RDA,
		ST_RDB,
		ST_RDC,
		ST_RDW,
		ST_DIFF,
		ST_SQUARE,
		ST_SUM,
		ST_SQRT,
		ST_CINIT,
		ST_CORD,
		ST_FIN,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              load;
		logic              wr;
		logic              hclr;
		logic              rd;
		rd_kind_t          kind;
		logic [STEP_W-1:0] step;
		logic              diff;
		logic              square;
		logic              sum;
		logic              sqrt_step;
		logic              cinit;
		logic              cord_step;
		logic              fin;
		logic              emit;
	} cmd_t;

	typedef struct packed {
		logic item_ok;
		logic h_last;
		logic height_ok;
		logic vec_ok;
		logic sqrt_last;
		logic slope_ok;
		logic out_full;
	} status_t;

	// atan(2^-i) in 1/65536 degree, rounded to nearest
	function automatic logic signed [ACC_W-1:0] atan_tab(input logic [4:0] i);
		case (i)
			5'd0:    atan_tab = 25'sd2949120;
			5'd1:    atan_tab = 25'sd1740967;
			5'd2:    atan_tab = 25'sd919879;
			5'd3:    atan_tab = 25'sd466945;
			5'd4:    atan_tab = 25'sd234379;
			5'd5:    atan_tab = 25'sd117304;
			5'd6:    atan_tab = 25'sd58666;
			5'd7:    atan_tab = 25'sd29335;
			5'd8:    atan_tab = 25'sd14668;
			5'd9:    atan_tab = 25'sd7334;
			5'd10:   atan_tab = 25'sd3667;
			5'd11:   atan_tab = 25'sd1833;
			5'd12:   atan_tab = 25'sd917;
			5'd13:   atan_tab = 25'sd458;
			5'd14:   atan_tab = 25'sd229;
			5'd15:   atan_tab = 25'sd115;
			5'd16:   atan_tab = 25'sd57;
			5'd17:   atan_tab = 25'sd29;
			5'd18:   atan_tab = 25'sd14;
			5'd19:   atan_tab = 25'sd7;
			default: atan_tab = 25'sd0;
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lcfd_if.sv =====
// lcfd_pt_if / lcfd_ft_if: valid-ready channels for input points and curb features
// depends on lcfd_pkg for field widths
`default_nettype none

interface lcfd_pt_if #(parameter int COORD_BITS = 18);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic signed [COORD_BITS-1:0] pos_z;
	logic                         first_in_scan;
	logic [lcfd_pkg::SIZE_W-1:0]  scan_size;

	modport source (output valid, pos_x, pos_y, pos_z, first_in_scan, scan_size,
		input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, first_in_scan, scan_size,
		output ready);
endinterface

interface lcfd_ft_if #(parameter int COORD_BITS = 18);
	logic                         valid;
	logic                         ready;
	logic [lcfd_pkg::INDEX_W-1:0] point_index;
	logic signed [COORD_BITS-1:0] feat_x;
	logic signed [COORD_BITS-1:0] feat_y;
	logic signed [COORD_BITS-1:0] feat_z;

	modport source (output valid, point_index, feat_x, feat_y, feat_z, input ready);
	modport sink (input valid, point_index, feat_x, feat_y, feat_z, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lcfd_ram.sv =====
// lcfd_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module lcfd_ram #(
	parameter int WIDTH = 54,
	parameter int DEPTH = 33
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lcfd_ctrl.sv =====
// lcfd_ctrl: sequencer for one point: history write, window scan, angle units, result
// depends on lcfd_pkg (state, command and status types)
`default_nettype none

module lcfd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire lcfd_pkg::status_t st,
	output lcfd_pkg::cmd_t         cmd
);

	lcfd_pkg::state_t state_q, state_n;
	logic [lcfd_pkg::STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcfd_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_n;
			step_q  <= (state_n != state_q) ? '0 : step_q + 1'b1;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			lcfd_pkg::ST_IDLE:   if (in_valid) state_n = lcfd_pkg::ST_WRITE;
			lcfd_pkg::ST_WRITE:  state_n = st.item_ok ? lcfd_pkg::ST_HREAD : lcfd_pkg::ST_IDLE;
			lcfd_pkg::ST_HREAD:  if (st.h_last) state_n = lcfd_pkg::ST_HLAST;
			lcfd_pkg::ST_HLAST:  state_n = lcfd_pkg::ST_HCHK;
			lcfd_pkg::ST_HCHK:   state_n = st.height_ok ? lcfd_pkg::ST_RDA : lcfd_pkg::ST_IDLE;
			lcfd_pkg::ST_RDA:    state_n = lcfd_pkg::ST_RDB;
			lcfd_pkg::ST_RDB:    state_n = lcfd_pkg::ST_RDC;
			lcfd_pkg::ST_RDC:    state_n = lcfd_pkg::ST_RDW;
			lcfd_pkg::ST_RDW:    state_n = lcfd_pkg::ST_DIFF;
			lcfd_pkg::ST_DIFF:   state_n = lcfd_pkg::ST_SQUARE;
			lcfd_pkg::ST_SQUARE: state_n = st.vec_ok ? lcfd_pkg::ST_SUM : lcfd_pkg::ST_IDLE;
			lcfd_pkg::ST_SUM:    state_n = lcfd_pkg::ST_SQRT;
			lcfd_pkg::ST_SQRT:   if (st.sqrt_last) state_n = lcfd_pkg::ST_CINIT;
			lcfd_pkg::ST_CINIT:  state_n = lcfd_pkg::ST_CORD;
			lcfd_pkg::ST_CORD: begin
				if (step_q == lcfd_pkg::STEP_W'(lcfd_pkg::CORDIC_STEPS - 1)) begin
					state_n = lcfd_pkg::ST_FIN;
				end
			end
			lcfd_pkg::ST_FIN:    state_n = lcfd_pkg::ST_DECIDE;
			lcfd_pkg::ST_DECIDE: state_n = st.slope_ok ? lcfd_pkg::ST_EMIT : lcfd_pkg::ST_IDLE;
			lcfd_pkg::ST_EMIT:   if (!st.out_full) state_n = lcfd_pkg::ST_IDLE;
			default:             state_n = lcfd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.kind = lcfd_pkg::RD_NONE;
		cmd.step = step_q;
		in_ready = 1'b0;
		unique case (state_q)
			lcfd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			lcfd_pkg::ST_WRITE: begin
				cmd.wr   = 1'b1;
				cmd.hclr = 1'b1;
			end
			lcfd_pkg::ST_HREAD: begin
				cmd.rd   = 1'b1;
				cmd.kind = lcfd_pkg::RD_HGT;
			end
			lcfd_pkg::ST_RDA: begin
				cmd.rd   = 1'b1;
				cmd.kind = lcfd_pkg::RD_PA;
			end
			lcfd_pkg::ST_RDB: begin
				cmd.rd   = 1'b1;
				cmd.kind = lcfd_pkg::RD_PB;
			end
			lcfd_pkg::ST_RDC: begin
				cmd.rd   = 1'b1;
				cmd.kind = lcfd_pkg::RD_PC;
			end
			lcfd_pkg::ST_DIFF:   cmd.diff = 1'b1;
			lcfd_pkg::ST_SQUARE: cmd.square = 1'b1;
			lcfd_pkg::ST_SUM:    cmd.sum = 1'b1;
			lcfd_pkg::ST_SQRT:   cmd.sqrt_step = 1'b1;
			lcfd_pkg::ST_CINIT:  cmd.cinit = 1'b1;
			lcfd_pkg::ST_CORD:   cmd.cord_step = 1'b1;
			lcfd_pkg::ST_FIN:    cmd.fin = 1'b1;
			lcfd_pkg::ST_EMIT:   cmd.emit = !st.out_full;
			default: begin
				cmd.emit = 1'b0;
			end
		endcase
	end

	// the history write always follows the point transfer
	a_load_then_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.wr) else $error("history write missing after point transfer");

	// a result only enters an empty output register
	a_emit_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !st.out_full) else $error("result overwrote pending feature");

	// a result is only produced after a passing slope decision
	a_emit_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && !$past(cmd.emit) |-> $past(st.slope_ok) || $past(state_q == lcfd_pkg::ST_EMIT))
		else $error("result without slope decision");

endmodule

`default_nettype wire

// ===== hw/rtl/lcfd_dp.sv =====
// lcfd_dp: datapath with point history ram, height window, root and cordic angle units
// depends on lcfd_pkg and lcfd_ram
`default_nettype none

module lcfd_dp #(
	parameter int MAX_REGION      = 16,
	parameter int COORD_BITS      = 18,
	parameter int MAX_SCAN_POINTS = 4096
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic signed [COORD_BITS-1:0]   pos_x,
	input  wire logic signed [COORD_BITS-1:0]   pos_y,
	input  wire logic signed [COORD_BITS-1:0]   pos_z,
	input  wire logic                           first_in_scan,
	input  wire logic [lcfd_pkg::SIZE_W-1:0]    scan_size,
	input  wire lcfd_pkg::cfg_t                 cfg,
	input  wire lcfd_pkg::cmd_t                 cmd,
	output lcfd_pkg::status_t                   st,
	input  wire logic                           out_ready,
	output logic                                out_valid,
	output logic [lcfd_pkg::INDEX_W-1:0]        point_index,
	output logic signed [COORD_BITS-1:0]        feat_x,
	output logic signed [COORD_BITS-1:0]        feat_y,
	output logic signed [COORD_BITS-1:0]        feat_z
);

	localparam int CB      = COORD_BITS;
	localparam int HDEPTH  = 2 * MAX_REGION + 1;
	localparam int SLOT_W  = $clog2(HDEPTH);
	localparam int CNT_W   = $clog2(MAX_SCAN_POINTS + 1);
	localparam int ROW_W   = 3 * CB;
	localparam int MAG_W   = CB + 1;
	localparam int MW      = (MAG_W > 31) ? 31 : MAG_W;
	localparam int SQ_W    = 2 * MW + 1;
	localparam int RT_W    = (SQ_W + 1) / 2;
	localparam int REM_W   = RT_W + 3;
	localparam int CW      = RT_W + 11;
	localparam int HD_W    = (CB + 1 > lcfd_pkg::HDIFF_W) ? CB + 1 : lcfd_pkg::HDIFF_W;
	localparam int DA_W    = lcfd_pkg::ANG_W + 1;
	localparam int ACC_W   = lcfd_pkg::ACC_W;
	localparam int ANG_W   = lcfd_pkg::ANG_W;
	localparam int STEP_W  = lcfd_pkg::STEP_W;
	localparam int REGION_W = lcfd_pkg::REGION_W;

	// point bookkeeping
	logic [CNT_W-1:0]   cnt_q, idx_q, size_q;
	logic [SLOT_W-1:0]  slot_q, cur_slot_q;
	logic signed [CB-1:0] pt_x_q, pt_y_q, pt_z_q;

	logic [REGION_W-1:0] h, s, r;
	logic [CNT_W-1:0]    idx_n, size_n;
	logic [SLOT_W-1:0]   slot_n;

	always_comb begin
		h = (32'(cfg.height_region) > MAX_REGION) ? REGION_W'(MAX_REGION) : cfg.height_region;
		s = (32'(cfg.slope_region) > MAX_REGION) ? REGION_W'(MAX_REGION) : cfg.slope_region;
		r = (h > s) ? h : s;
		idx_n  = first_in_scan ? '0 : cnt_q;
		slot_n = first_in_scan ? '0 : slot_q;
		size_n = (32'(scan_size) > MAX_SCAN_POINTS) ? CNT_W'(MAX_SCAN_POINTS) : CNT_W'(scan_size);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			idx_q      <= '0;
			size_q     <= '0;
			slot_q     <= '0;
			cur_slot_q <= '0;
		end else if (cmd.load) begin
			idx_q      <= idx_n;
			cur_slot_q <= slot_n;
			if (first_in_scan) begin
				size_q <= size_n;
			end
			// counter saturates, ring slot freezes with it
			if (32'(idx_n) < MAX_SCAN_POINTS) begin
				cnt_q  <= idx_n + 1'b1;
				slot_q <= (32'(slot_n) == HDEPTH - 1) ? '0 : slot_n + 1'b1;
			end else begin
				cnt_q  <= idx_n;
				slot_q <= slot_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pt_x_q <= pos_x;
			pt_y_q <= pos_y;
			pt_z_q <= pos_z;
		end
	end

	// history ram, slots addressed back from the newest point
	logic [STEP_W-1:0] off;
	logic [SLOT_W-1:0] raddr;
	logic [ROW_W-1:0]  rdata;
	int                slot_tmp;

	always_comb begin
		case (cmd.kind)
			lcfd_pkg::RD_HGT: off = STEP_W'(r) + STEP_W'(h) - cmd.step;
			lcfd_pkg::RD_PA:  off = STEP_W'(r) + STEP_W'(s);
			lcfd_pkg::RD_PB:  off = STEP_W'(r) - STEP_W'(s);
			lcfd_pkg::RD_PC:  off = STEP_W'(r);
			default:          off = '0;
		endcase
		slot_tmp = int'(cur_slot_q) - int'(off);
		if (slot_tmp < 0) begin
			slot_tmp = slot_tmp + HDEPTH;
		end
		raddr = SLOT_W'(slot_tmp);
	end

	lcfd_ram #(
		.WIDTH (ROW_W),
		.DEPTH (HDEPTH)
	) u_hist (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (cur_slot_q),
		.wdata ({pt_x_q, pt_y_q, pt_z_q}),
		.raddr (raddr),
		.rdata (rdata)
	);

	lcfd_pkg::rd_kind_t kind_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s1 <= lcfd_pkg::RD_NONE;
		end else begin
			kind_s1 <= cmd.rd ? cmd.kind : lcfd_pkg::RD_NONE;
		end
	end

	// height window min/max
	logic signed [CB-1:0] zmin_q, zmax_q, rd_z;
	logic                 hfirst_q;
	logic [HD_W-1:0]      hdiff;

	assign rd_z = rdata[CB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hfirst_q <= 1'b1;
		end else if (cmd.hclr) begin
			hfirst_q <= 1'b1;
		end else if (kind_s1 == lcfd_pkg::RD_HGT) begin
			hfirst_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (kind_s1 == lcfd_pkg::RD_HGT) begin
			if (hfirst_q || rd_z > zmax_q) begin
				zmax_q <= rd_z;
			end
			if (hfirst_q || rd_z < zmin_q) begin
				zmin_q <= rd_z;
			end
		end
	end

	assign hdiff = HD_W'(zmax_q) - HD_W'(zmin_q);

	// points a (j-s), b (j+s), c (j)
	logic [ROW_W-1:0] row_a_q, row_b_q, row_c_q;

	always_ff @(posedge clk) begin
		if (kind_s1 == lcfd_pkg::RD_PA) row_a_q <= rdata;
		if (kind_s1 == lcfd_pkg::RD_PB) row_b_q <= rdata;
		if (kind_s1 == lcfd_pkg::RD_PC) row_c_q <= rdata;
	end

	function automatic int norm_sh(input logic [MAG_W-1:0] m);
		int sh;
		sh = 0;
		for (int i = 31; i < MAG_W; i++) begin
			if (m[i]) sh = i - 30;
		end
		return sh;
	endfunction

	function automatic logic [MAG_W-1:0] mag_of(input logic signed [MAG_W-1:0] d);
		return d[MAG_W-1] ? MAG_W'(0) - d : d;
	endfunction

	// lane 0: angle a->b, lane 1: angle a->c
	logic [MW-1:0]       ax_q [2], ay_q [2], az_q [2];
	logic                neg_q [2], nz_q [2];
	logic [2*MW-1:0]     px_q [2], py_q [2];
	logic [2*RT_W-1:0]   sum_q [2];
	logic [REM_W-1:0]    rem_q [2];
	logic [RT_W-1:0]     root_q [2];
	logic signed [CW-1:0]    cx_q [2], cy_q [2];
	logic signed [ACC_W-1:0] acc_q [2];
	logic signed [ANG_W-1:0] ang_q [2];

	always_ff @(posedge clk) begin
		logic [ROW_W-1:0]        far;
		logic signed [MAG_W-1:0] dx, dy, dz;
		logic [MAG_W-1:0]        mx, my, mz;
		int                      sh, bi;
		logic [REM_W-1:0]        rem_t, trial;
		logic signed [CW-1:0]    xs, ys;
		logic signed [ACC_W-1:0] rnd, ta;
		for (int l = 0; l < 2; l++) begin
			far = (l == 0) ? row_b_q : row_c_q;
			if (cmd.diff) begin
				dx = MAG_W'($signed(far[3*CB-1:2*CB])) - MAG_W'($signed(row_a_q[3*CB-1:2*CB]));
				dy = MAG_W'($signed(far[2*CB-1:CB])) - MAG_W'($signed(row_a_q[2*CB-1:CB]));
				dz = MAG_W'($signed(far[CB-1:0])) - MAG_W'($signed(row_a_q[CB-1:0]));
				mx = mag_of(dx);
				my = mag_of(dy);
				mz = mag_of(dz);
				sh = norm_sh(mx | my | mz);
				ax_q[l]  <= MW'(mx >> sh);
				ay_q[l]  <= MW'(my >> sh);
				az_q[l]  <= MW'(mz >> sh);
				neg_q[l] <= dz[MAG_W-1];
				nz_q[l]  <= (mx | my | mz) != '0;
			end
			if (cmd.square) begin
				px_q[l] <= (2*MW)'(ax_q[l]) * (2*MW)'(ax_q[l]);
				py_q[l] <= (2*MW)'(ay_q[l]) * (2*MW)'(ay_q[l]);
			end
			if (cmd.sum) begin
				sum_q[l]  <= (2*RT_W)'(px_q[l]) + (2*RT_W)'(py_q[l]);
				rem_q[l]  <= '0;
				root_q[l] <= '0;
			end
			// restoring square root, two radicand bits a step
			if (cmd.sqrt_step) begin
				bi    = 2 * (RT_W - 1 - int'(cmd.step));
				rem_t = {rem_q[l][REM_W-3:0], sum_q[l][bi +: 2]};
				trial = {root_q[l], 2'b01};
				if (rem_t >= trial) begin
					rem_q[l]  <= rem_t - trial;
					root_q[l] <= {root_q[l][RT_W-2:0], 1'b1};
				end else begin
					rem_q[l]  <= rem_t;
					root_q[l] <= {root_q[l][RT_W-2:0], 1'b0};
				end
			end
			if (cmd.cinit) begin
				cx_q[l]  <= CW'({root_q[l], 8'd0});
				cy_q[l]  <= CW'({az_q[l], 8'd0});
				acc_q[l] <= '0;
			end
			if (cmd.cord_step) begin
				xs = cx_q[l] >>> cmd.step;
				ys = cy_q[l] >>> cmd.step;
				ta = lcfd_pkg::atan_tab(cmd.step[4:0]);
				if (!cy_q[l][CW-1]) begin
					cx_q[l]  <= cx_q[l] + ys;
					cy_q[l]  <= cy_q[l] - xs;
					acc_q[l] <= acc_q[l] + ta;
				end else begin
					cx_q[l]  <= cx_q[l] - ys;
					cy_q[l]  <= cy_q[l] + xs;
					acc_q[l] <= acc_q[l] - ta;
				end
			end
			if (cmd.fin) begin
				rnd = (acc_q[l] + ACC_W'(128)) >>> 8;
				ang_q[l] <= neg_q[l] ? ANG_W'(-rnd) : ANG_W'(rnd);
			end
		end
	end

	logic signed [DA_W-1:0] ang_diff;
	assign ang_diff = DA_W'(ang_q[0]) - DA_W'(ang_q[1]);

	// result register
	logic out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.emit) begin
			out_full_q <= 1'b1;
		end else if (out_ready) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			point_index <= lcfd_pkg::INDEX_W'(idx_q - CNT_W'(r));
			feat_x      <= row_c_q[3*CB-1:2*CB];
			feat_y      <= row_c_q[2*CB-1:CB];
			feat_z      <= row_c_q[CB-1:0];
		end
	end

	assign out_valid = out_full_q;

	always_comb begin
		st.item_ok   = (idx_q < size_q) && (32'(size_q) >= 32'(cfg.min_scan_points))
			&& (32'(idx_q) >= 2 * 32'(r));
		st.h_last    = cmd.step == {h, 1'b0};
		st.height_ok = (hdiff >= HD_W'(cfg.height_diff_min))
			&& (hdiff <= HD_W'(cfg.height_diff_max));
		st.vec_ok    = nz_q[0] && nz_q[1];
		st.sqrt_last = 32'(cmd.step) == RT_W - 1;
		st.slope_ok  = ang_diff > DA_W'(cfg.slope_threshold);
		st.out_full  = out_full_q;
	end

	// window extremes are loaded together on the first capture
	a_minmax: assert property (@(posedge clk) disable iff (!arst_n)
		!hfirst_q |-> zmax_q >= zmin_q) else $error("height window min above max");

	// a pending result only leaves on a transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_full_q && !out_ready && !cmd.emit |=> out_full_q && $stable(point_index))
		else $error("pending feature lost");

endmodule

`default_nettype wire

// ===== hw/rtl/lidar_curb_feature_detector.sv =====
// lidar_curb_feature_detector: top level, apb register file, controller and datapath
// depends on lcfd_pkg, lcfd_if, lcfd_ctrl, lcfd_dp (and lcfd_ram below it)
//
//  channel   dir  protocol        payload
//  points    in   valid/ready     pos_x, pos_y, pos_z, first_in_scan, scan_size
//  features  out  valid/ready     point_index, feat_x, feat_y, feat_z
//  apb       in   psel/penable    six config registers at byte address 4*i
//
// one point at a time: points.ready is high only while the sequencer is idle
// a point rejected before the window scan only gets its history write; a point that reaches
// the slope decision also runs the height window scan, the reads of points a, b and c,
// the root and the cordic, and loads a feature when the decision passes; the history scan
// does one read a cycle, the root takes two bits a cycle and the cordic runs 20 steps
// a found feature waits in the output register; the next point is taken meanwhile,
// a second feature holds the sequencer until the first one is transferred
// reset is asynchronous active low and needs no clearing pass
`default_nettype none

module lidar_curb_feature_detector #(
	parameter int MAX_REGION      = 16,
	parameter int COORD_BITS      = 18,
	parameter int MAX_SCAN_POINTS = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	lcfd_pt_if.sink                            points,
	lcfd_ft_if.source                          features,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lcfd_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	// register file
	lcfd_pkg::cfg_t cfg_q;
	logic [2:0]     reg_idx;
	logic           wr_en;

	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.height_region   <= 5'd5;
			cfg_q.slope_region    <= 5'd5;
			cfg_q.slope_threshold <= 17'sd2560;
			cfg_q.height_diff_min <= 17'd50;
			cfg_q.height_diff_max <= 17'd300;
			cfg_q.min_scan_points <= 13'd500;
		end else if (wr_en) begin
			unique case (reg_idx)
				lcfd_pkg::REG_HEIGHT_REGION:   cfg_q.height_region   <= pwdata[4:0];
				lcfd_pkg::REG_SLOPE_REGION:    cfg_q.slope_region    <= pwdata[4:0];
				lcfd_pkg::REG_SLOPE_THRESHOLD: cfg_q.slope_threshold <= pwdata[16:0];
				lcfd_pkg::REG_HEIGHT_DIFF_MIN: cfg_q.height_diff_min <= pwdata[16:0];
				lcfd_pkg::REG_HEIGHT_DIFF_MAX: cfg_q.height_diff_max <= pwdata[16:0];
				lcfd_pkg::REG_MIN_SCAN_POINTS: cfg_q.min_scan_points <= pwdata[12:0];
				default: begin
					// unknown register, write dropped
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			lcfd_pkg::REG_HEIGHT_REGION:   prdata = 32'(cfg_q.height_region);
			lcfd_pkg::REG_SLOPE_REGION:    prdata = 32'(cfg_q.slope_region);
			lcfd_pkg::REG_SLOPE_THRESHOLD: prdata = 32'(unsigned'(cfg_q.slope_threshold));
			lcfd_pkg::REG_HEIGHT_DIFF_MIN: prdata = 32'(cfg_q.height_diff_min);
			lcfd_pkg::REG_HEIGHT_DIFF_MAX: prdata = 32'(cfg_q.height_diff_max);
			lcfd_pkg::REG_MIN_SCAN_POINTS: prdata = 32'(cfg_q.min_scan_points);
			default:                       prdata = '0;
		endcase
	end

	// sequencer and datapath talk only through command and status
	lcfd_pkg::cmd_t    cmd;
	lcfd_pkg::status_t st;

	lcfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (points.valid),
		.in_ready (points.ready),
		.st       (st),
		.cmd      (cmd)
	);

	lcfd_dp #(
		.MAX_REGION      (MAX_REGION),
		.COORD_BITS      (COORD_BITS),
		.MAX_SCAN_POINTS (MAX_SCAN_POINTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.pos_x         (points.pos_x),
		.pos_y         (points.pos_y),
		.pos_z         (points.pos_z),
		.first_in_scan (points.first_in_scan),
		.scan_size     (points.scan_size),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.st            (st),
		.out_ready     (features.ready),
		.out_valid     (features.valid),
		.point_index   (features.point_index),
		.feat_x        (features.feat_x),
		.feat_y        (features.feat_y),
		.feat_z        (features.feat_z)
	);

	// no point transfer while a point is still in work
	a_one_point: assert property (@(posedge clk) disable iff (!arst_n)
		points.valid && points.ready |=> !points.ready) else $error("second point taken early");

endmodule

`default_nettype wire

// ===== sim/lidar_curb_feature_detector_test.sv =====
// lidar_curb_feature_detector_test: self-checking bench for the curb feature detector
// drives point transfers and apb writes, predicts features and checks each feature transfer
// depends on lcfd_pkg, lcfd_if and the rtl of lidar_curb_feature_detector
`default_nettype none

module lidar_curb_feature_detector_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB        = 18;
	localparam int RING      = 33;
	localparam int REGION_CAP = 16;
	localparam int SCAN_CAP  = 4096;
	localparam int IDLE_LIMIT = 20000;
	localparam int LONG_HOLD = 3000;
	localparam int DRAIN_CYCLES = 250;
	localparam int RANDOM_POINTS = 1200;
	// register slots past the end of the map
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic [lcfd_pkg::INDEX_W-1:0] idx;
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic signed [CB-1:0] z;
	} feature_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [lcfd_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	lcfd_pt_if #(.COORD_BITS(CB)) pts ();
	lcfd_ft_if #(.COORD_BITS(CB)) fts ();

	lidar_curb_feature_detector uut (
		.clk(clk), .arst_n(arst_n), .points(pts), .features(fts),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state: history ring, line position and register copy
	longint hist_x [RING];
	longint hist_y [RING];
	longint hist_z [RING];
	int unsigned line_pos;
	int unsigned line_len;
	logic [lcfd_pkg::REGION_W-1:0]     cfg_h;
	logic [lcfd_pkg::REGION_W-1:0]     cfg_s;
	logic signed [lcfd_pkg::THR_W-1:0] cfg_thr;
	logic [lcfd_pkg::HDIFF_W-1:0]      cfg_hmin;
	logic [lcfd_pkg::HDIFF_W-1:0]      cfg_hmax;
	logic [lcfd_pkg::SIZE_W-1:0]       cfg_minpts;

	feature_t pending_features [$];
	int errors;
	int points_sent;
	int features_seen;
	bit rx_calm, tx_calm, hold_req;

	// atan(2^-i) in 1/65536 degree
	localparam longint ATAN_DEG [20] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
	};

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// elevation angle from ring slot a to slot b in 1/256 degree; 0 on a zero vector
	function automatic bit elevation(int unsigned a, int unsigned b, output longint ang);
		longint dz, ax, ay, az, m, x, y, acc, xs, ys;
		int sh;
		dz = hist_z[b] - hist_z[a];
		ax = hist_x[b] - hist_x[a];
		ay = hist_y[b] - hist_y[a];
		ax = ax < 0 ? -ax : ax;
		ay = ay < 0 ? -ay : ay;
		az = dz < 0 ? -dz : dz;
		m = ax | ay | az;
		ang = 0;
		if (m == 0) return 0;
		sh = 0;
		while ((m >>> sh) >= (64'sd1 << 31)) sh++;
		ax = ax >>> sh; ay = ay >>> sh; az = az >>> sh;
		x = longint'(int_sqrt(longint'(ax * ax + ay * ay))) * 256;
		y = az * 256;
		acc = 0;
		for (int i = 0; i < 20; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; acc = acc + ATAN_DEG[i];
			end else begin
				x = x - ys; y = y + xs; acc = acc - ATAN_DEG[i];
			end
		end
		acc = (acc + 128) >>> 8;
		ang = dz < 0 ? -acc : acc;
		return 1;
	endfunction

	// one accepted point: update history, decide the point r back, return 1 on a feature
	function automatic bit detect_curb_point(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
			logic signed [CB-1:0] pz, logic first, logic [lcfd_pkg::SIZE_W-1:0] size,
			output feature_t ft);
		int unsigned idx, h, s, r, j, slot;
		longint zmax, zmin, a1, a2, diff;
		ft = '0;
		if (first) begin
			line_pos = 0;
			line_len = size > SCAN_CAP ? SCAN_CAP : size;
		end
		idx = line_pos;
		slot = idx % RING;
		hist_x[slot] = px; hist_y[slot] = py; hist_z[slot] = pz;
		if (line_pos < SCAN_CAP) line_pos++;
		if (idx >= line_len || line_len < cfg_minpts) return 0;
		h = cfg_h > REGION_CAP ? REGION_CAP : cfg_h;
		s = cfg_s > REGION_CAP ? REGION_CAP : cfg_s;
		r = h > s ? h : s;
		if (idx < 2 * r) return 0;
		j = idx - r;
		zmax = hist_z[j % RING];
		zmin = zmax;
		for (int unsigned k = j - h; k <= j + h; k++) begin
			if (hist_z[k % RING] > zmax) zmax = hist_z[k % RING];
			if (hist_z[k % RING] < zmin) zmin = hist_z[k % RING];
		end
		diff = zmax - zmin;
		if (diff < cfg_hmin || diff > cfg_hmax) return 0;
		if (!elevation((j - s) % RING, (j + s) % RING, a1)) return 0;
		if (!elevation((j - s) % RING, j % RING, a2)) return 0;
		if (!(a1 - a2 > longint'(cfg_thr))) return 0;
		ft.idx = j[lcfd_pkg::INDEX_W-1:0];
		ft.x = hist_x[j % RING];
		ft.y = hist_y[j % RING];
		ft.z = hist_z[j % RING];
		return 1;
	endfunction

	// clock and reset
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	// random gap length: mostly short, now and then long
	function automatic int pick_gap(bit calm);
		if (calm) return 0;
		if ($urandom_range(0, 2) != 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
		return $urandom_range(1, 3);
	endfunction

	// feature receiver with random stalls and the long hold-off on request
	initial begin
		int gap;
		fts.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				fts.ready <= 0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 0;
			end else begin
				gap = pick_gap(rx_calm);
				if (gap > 0) begin
					fts.ready <= 0;
					repeat (gap - 1) @(posedge clk);
				end else begin
					fts.ready <= 1;
				end
			end
		end
	end

	// feature checker
	always @(posedge clk) begin
		feature_t exp_ft;
		if (arst_n && fts.valid && fts.ready) begin
			features_seen++;
			if (pending_features.size() == 0) begin
				$error("unexpected feature transfer: index %0d", fts.point_index);
				errors++;
			end else begin
				exp_ft = pending_features.pop_front();
				if (fts.point_index !== exp_ft.idx) begin
					$error("point_index: expected %0d, got %0d", exp_ft.idx, fts.point_index);
					errors++;
				end
				if (fts.feat_x !== exp_ft.x) begin
					$error("feat_x: expected %0d, got %0d", exp_ft.x, fts.feat_x);
					errors++;
				end
				if (fts.feat_y !== exp_ft.y) begin
					$error("feat_y: expected %0d, got %0d", exp_ft.y, fts.feat_y);
					errors++;
				end
				if (fts.feat_z !== exp_ft.z) begin
					$error("feat_z: expected %0d, got %0d", exp_ft.z, fts.feat_z);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	int idle_cycles;
	always @(posedge clk) begin
		if ((pts.valid && pts.ready) || (fts.valid && fts.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// one point transfer; valid stays high when no gap follows
	task automatic send_point(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
			logic signed [CB-1:0] pz, logic first, logic [lcfd_pkg::SIZE_W-1:0] size);
		feature_t ft;
		int gap;
		pts.valid <= 1;
		pts.pos_x <= px;
		pts.pos_y <= py;
		pts.pos_z <= pz;
		pts.first_in_scan <= first;
		pts.scan_size <= size;
		do @(posedge clk); while (!pts.ready);
		points_sent++;
		if (detect_curb_point(px, py, pz, first, size, ft))
			pending_features.insert(pending_features.size(), ft);
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			pts.valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic stop_points();
		pts.valid <= 0;
		@(posedge clk);
	endtask

	// wait until every feature is out and the sequencer has finished any last decision
	task automatic drain_block();
		stop_points();
		while (pending_features.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// apb write: setup phase, access phase, then the bus goes idle
	task automatic reg_write(logic [2:0] regno, logic [31:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= lcfd_pkg::PADDR_W'(regno) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		case (regno)
			lcfd_pkg::REG_HEIGHT_REGION:   cfg_h = value[lcfd_pkg::REGION_W-1:0];
			lcfd_pkg::REG_SLOPE_REGION:    cfg_s = value[lcfd_pkg::REGION_W-1:0];
			lcfd_pkg::REG_SLOPE_THRESHOLD: cfg_thr = value[lcfd_pkg::THR_W-1:0];
			lcfd_pkg::REG_HEIGHT_DIFF_MIN: cfg_hmin = value[lcfd_pkg::HDIFF_W-1:0];
			lcfd_pkg::REG_HEIGHT_DIFF_MAX: cfg_hmax = value[lcfd_pkg::HDIFF_W-1:0];
			lcfd_pkg::REG_MIN_SCAN_POINTS: cfg_minpts = value[lcfd_pkg::SIZE_W-1:0];
			default: ;
		endcase
		psel <= 0;
		penable <= 0;
		@(posedge clk);
	endtask

	task automatic set_config(int h, int s, int thr, int hmin, int hmax, int minpts);
		drain_block();
		reg_write(lcfd_pkg::REG_HEIGHT_REGION, h);
		reg_write(lcfd_pkg::REG_SLOPE_REGION, s);
		reg_write(lcfd_pkg::REG_SLOPE_THRESHOLD, thr);
		reg_write(lcfd_pkg::REG_HEIGHT_DIFF_MIN, hmin);
		reg_write(lcfd_pkg::REG_HEIGHT_DIFF_MAX, hmax);
		reg_write(lcfd_pkg::REG_MIN_SCAN_POINTS, minpts);
	endtask

	function automatic int srand_range(int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	// a scan line along x with a step in height; extra points run past the line end
	task automatic send_curb_line(int npts, int size_field, int step_at, int rise, int jitter);
		int x0, y0, z0, dxs;
		x0 = srand_range(100000);
		y0 = srand_range(100000);
		z0 = srand_range(100000);
		dxs = $urandom_range(20, 200);
		for (int i = 0; i < npts; i++)
			send_point(CB'(x0 + i * dxs), CB'(y0 + srand_range(jitter)),
				CB'(z0 + (i >= step_at ? rise : 0) + srand_range(jitter)), i == 0,
				lcfd_pkg::SIZE_W'(i == 0 ? size_field : int'($urandom_range(0, 8191))));
	endtask

	task automatic send_noise_point(bit first);
		send_point(CB'($urandom), CB'($urandom), CB'($urandom), first,
			lcfd_pkg::SIZE_W'($urandom_range(0, 8191)));
	endtask

	// points before any line start give nothing
	task automatic test_no_line_start();
		for (int i = 0; i < 4; i++) send_noise_point(0);
		send_point(CB'(0), CB'(0), CB'(0), 1'b0, lcfd_pkg::SIZE_W'(100));
	endtask

	// extremes of coordinates and registers, plus the special cases
	task automatic test_directed();
		set_config(2, 2, 2560, 50, 300, 0);
		// a plain curb gives features around the step
		send_curb_line(14, 14, 7, 150, 0);
		// coordinate extremes and a zero vector
		send_point(CB'(-131072), CB'(-131072), CB'(-131072), 1'b1, lcfd_pkg::SIZE_W'(8));
		send_point(CB'(131071), CB'(131071), CB'(131071), 1'b0, lcfd_pkg::SIZE_W'(8));
		for (int i = 0; i < 6; i++)
			send_point(CB'(0), CB'(0), CB'(0), 1'b0, lcfd_pkg::SIZE_W'(8));
		drain_block();
		// unknown register slots are ignored
		reg_write(REG_SPARE_A, 32'hffff_ffff);
		reg_write(REG_SPARE_B, 32'h1234_5678);
		set_config(31, 31, -46080, 0, 131071, 0);
		send_curb_line(40, 40, 20, 500, 3);
		set_config(0, 0, 46080, 0, 131071, 0);
		send_curb_line(6, 6, 3, 100, 0);
		set_config(0, 1, -46080, 0, 131071, 4096);
		send_curb_line(8, 8, 4, 100, 0);
		set_config(3, 0, -46080, 131071, 0, 0);
		send_curb_line(8, 20, 4, 100, 0);
	endtask

	// random configurations with curb lines, some with odd size fields, and some noise
	task automatic test_random_lines();
		int h, s, thr, hmin, hmax, minpts, n, sz;
		while (points_sent < RANDOM_POINTS) begin
			h = $urandom_range(0, 7) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 5);
			s = $urandom_range(0, 7) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 5);
			thr = $urandom_range(0, 5) == 0 ? srand_range(46080) : srand_range(3000);
			hmin = $urandom_range(0, 80);
			hmax = $urandom_range(0, 5) == 0 ? $urandom_range(0, 131071)
				: $urandom_range(100, 600);
			minpts = $urandom_range(0, 9) == 0 ? $urandom_range(0, 8191)
				: $urandom_range(0, 40);
			set_config(h, s, thr, hmin, hmax, minpts);
			tx_calm = $urandom_range(0, 3) == 0;
			rx_calm = $urandom_range(0, 3) == 0;
			repeat ($urandom_range(3, 6)) begin
				if ($urandom_range(0, 6) == 0) begin
					repeat ($urandom_range(3, 20)) send_noise_point($urandom_range(0, 7) == 0);
				end else begin
					n = $urandom_range(5, 60);
					case ($urandom_range(0, 5))
						0:       sz = $urandom_range(0, n);
						1:       sz = $urandom_range(4097, 8191);
						default: sz = n;
					endcase
					send_curb_line(n, sz, $urandom_range(0, n), srand_range(400),
						$urandom_range(0, 30));
				end
			end
		end
		tx_calm = 0;
		rx_calm = 0;
	endtask

	// receiver holds off for a long stretch while points keep coming
	task automatic test_output_backpressure();
		set_config(1, 1, 0, 20, 100000, 0);
		hold_req = 1;
		tx_calm = 1;
		repeat (4) send_curb_line(30, 30, 15, 200, 20);
		tx_calm = 0;
	endtask

	initial begin
		errors = 0;
		points_sent = 0;
		features_seen = 0;
		hold_req = 0;
		rx_calm = 0;
		tx_calm = 0;
		line_pos = 0;
		line_len = 0;
		cfg_h = 5;
		cfg_s = 5;
		cfg_thr = 2560;
		cfg_hmin = 50;
		cfg_hmax = 300;
		cfg_minpts = 500;
		foreach (hist_x[i]) begin
			hist_x[i] = 0; hist_y[i] = 0; hist_z[i] = 0;
		end
		pts.valid = 0;
		pts.pos_x = 0;
		pts.pos_y = 0;
		pts.pos_z = 0;
		pts.first_in_scan = 0;
		pts.scan_size = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		@(posedge arst_n);
		@(posedge clk);

		test_no_line_start();
		test_directed();
		test_random_lines();
		test_output_backpressure();

		// all points are in: wait for the last features and a quiet tail
		drain_block();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
